>>> rtl/mcs51_uart_pkg.sv
// Shared constants for the 8051 serial port model: request kinds,
// configuration register indexes and reset values. No dependencies.
package mcs51_uart_pkg;

    localparam int RX_DEPTH_DEF   = 16;
    localparam int SPACING_US_DEF = 1000;

    localparam logic [1:0] KIND_TX_WRITE = 2'd0;
    localparam logic [1:0] KIND_RX_PUSH  = 2'd1;
    localparam logic [1:0] KIND_DELIVER  = 2'd2;
    localparam logic [1:0] KIND_CLEAR    = 2'd3;

    localparam logic [2:0] REG_SERIAL_MODE   = 3'd0;
    localparam logic [2:0] REG_RECEIVE_EN    = 3'd1;
    localparam logic [2:0] REG_T1_RUNNING    = 3'd2;
    localparam logic [2:0] REG_T1_MODE       = 3'd3;
    localparam logic [2:0] REG_BAUD_DOUBLE   = 3'd4;
    localparam logic [2:0] REG_T1_FAST       = 3'd5;
    localparam logic [2:0] REG_T1_RELOAD     = 3'd6;
    localparam logic [2:0] REG_CLOCK_HZ      = 3'd7;

    localparam logic [30:0] CLOCK_HZ_RESET   = 31'd11059200;
    localparam logic [1:0]  T1_MODE_RELOAD   = 2'd2;
    localparam logic [1:0]  MASK_BAUD        = 2'b01;
    localparam logic [1:0]  MASK_MODE        = 2'b10;
    localparam logic [32:0] FRAME_NUM_11     = 33'd11000000;
    localparam logic [32:0] FRAME_NUM_10     = 33'd10000000;
    localparam int          DIV_STEPS        = 33;

endpackage

>>> rtl/mcs51_uart_model.sv
// Top level of the 8051 serial port model: transmit path with baud and
// frame-time computation, receive FIFO and delivery. Uses mcs51_uart_pkg.
//
//  channel   | ports                         | moves
//  ----------+-------------------------------+------------------------------
//  s_*       | s_valid/s_ready + fields      | one request (tx, push, tick, clear)
//  m_*       | m_valid/m_ready + fields      | one result per request
//  cfg_*     | cfg_wr_en, cfg_index, data    | register writes, no wait
//
// A request is taken only in idle. Push, clear, drop and not-ready transmit
// requests show their result in the cycle after acceptance; a delivery
// goes first through one registered store read. A ready transmit runs the
// shared restoring divider twice, 33 steps plus a turnaround each (baud,
// then frame time), and only once when the baud quotient is zero.
// The divider is the limit. Reset is synchronous, active low; it clears
// flags, pointers and counts. A stalled result holds in the output
// registers until m_ready.
module mcs51_uart_model
    import mcs51_uart_pkg::*;
#(
    parameter int RX_DEPTH   = RX_DEPTH_DEF,
    parameter int SPACING_US = SPACING_US_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_data_byte,
    input  logic [47:0] s_now_us,
    input  logic        s_clear_ti,
    input  logic        s_clear_ri,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_overwrite,
    output logic [1:0]  m_not_ready_mask,
    output logic [31:0] m_baud_hz,
    output logic [23:0] m_frame_us,
    output logic [7:0]  m_buffer_value,
    output logic        m_delivered,
    output logic [31:0] m_dropped_total,
    output logic        m_ti_flag,
    output logic        m_ri_flag,
    output logic        m_interrupt
);

    localparam int PW = $clog2(2 * RX_DEPTH);
    localparam int IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [PW-1:0] PTR_LAST  = PW'(2 * RX_DEPTH - 1);
    localparam logic [PW-1:0] PTR_SPAN  = PW'(2 * RX_DEPTH);
    localparam logic [PW-1:0] DEPTH_P   = PW'(RX_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_READ, ST_OUT} state_t;

    // configuration
    logic [1:0]  serial_mode_reg;
    logic        receive_enable_reg, t1_running_reg, baud_double_reg, t1_fast_reg;
    logic [1:0]  t1_mode_reg;
    logic [7:0]  t1_reload_reg;
    logic [30:0] clock_hz_reg;

    // block state
    state_t        state_reg;
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [7:0]    data_buffer_reg;
    logic          ti_reg, ri_reg, ever_reg;
    logic [47:0]   last_us_reg;
    logic [31:0]   drop_reg;
    logic [47:0]   now_reg;

    // result registers
    logic        tx_valid_reg, overwrite_reg, delivered_reg, irq_reg;
    logic [7:0]  tx_byte_reg;
    logic [1:0]  mask_reg;
    logic [31:0] baud_reg;
    logic [23:0] frame_reg;

    // shared divider
    logic [31:0] rem_reg, den_reg;
    logic [32:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        phase_reg;

    // receive store
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] rd_data_reg;

    // FIFO arithmetic
    logic [PW-1:0] used, wr_inc, rd_inc;
    logic [IW-1:0] wr_idx, rd_idx;
    logic          fifo_full, fifo_empty;

    assign used       = (wr_ptr_reg >= rd_ptr_reg) ? (wr_ptr_reg - rd_ptr_reg)
                                                   : (wr_ptr_reg + PTR_SPAN - rd_ptr_reg);
    assign fifo_full  = (used >= DEPTH_P);
    assign fifo_empty = (used == '0);
    assign wr_inc     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_idx     = IW'((wr_ptr_reg >= DEPTH_P) ? wr_ptr_reg - DEPTH_P : wr_ptr_reg);
    assign rd_idx     = IW'((rd_ptr_reg >= DEPTH_P) ? rd_ptr_reg - DEPTH_P : rd_ptr_reg);

    // transmit readiness and baud divisor 128 * t * (256 - reload)
    logic [1:0]  tx_mask;
    logic [8:0]  span_n;
    logic [10:0] span_nt;
    logic [31:0] baud_den;
    logic [32:0] baud_num;

    assign tx_mask  = (serial_mode_reg[0] ? 2'b00 : MASK_MODE)
                    | ((t1_running_reg && t1_mode_reg == T1_MODE_RELOAD) ? 2'b00 : MASK_BAUD);
    assign span_n   = 9'd256 - {1'b0, t1_reload_reg};
    assign span_nt  = t1_fast_reg ? {2'b00, span_n}
                                  : ({2'b00, span_n} + {1'b0, span_n, 1'b0});
    assign baud_den = {14'd0, span_nt, 7'd0};
    assign baud_num = baud_double_reg ? {1'b0, clock_hz_reg, 1'b0} : {2'b00, clock_hz_reg};

    // one restoring step
    logic [32:0] trial;
    logic        take;
    logic [32:0] trial_sub;
    assign trial     = {rem_reg, quo_reg[32]};
    assign take      = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    // delivery gate and saturating drop sums
    logic [47:0] elapsed;
    logic        early, deliver_ok;
    logic [32:0] flush_sum;
    logic [31:0] drop_inc;
    assign elapsed    = s_now_us - last_us_reg;
    assign early      = ever_reg && (elapsed < 48'(SPACING_US));
    assign deliver_ok = !fifo_empty && receive_enable_reg && !early;
    assign flush_sum  = {1'b0, drop_reg} + 33'(used);
    assign drop_inc   = (drop_reg == 32'hFFFF_FFFF) ? drop_reg : drop_reg + 1'b1;

    logic accept;
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // store write on push, registered read at the read pointer
    always_ff @(posedge aclk) begin
        if (accept && s_kind == KIND_RX_PUSH && !fifo_full) begin
            rx_mem[wr_idx] <= s_data_byte;
        end
        rd_data_reg <= rx_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serial_mode_reg    <= '0;
            receive_enable_reg <= 1'b0;
            t1_running_reg     <= 1'b0;
            t1_mode_reg        <= '0;
            baud_double_reg    <= 1'b0;
            t1_fast_reg        <= 1'b0;
            t1_reload_reg      <= '0;
            clock_hz_reg       <= CLOCK_HZ_RESET;
            state_reg          <= ST_IDLE;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            data_buffer_reg    <= '0;
            ti_reg             <= 1'b0;
            ri_reg             <= 1'b0;
            ever_reg           <= 1'b0;
            last_us_reg        <= '0;
            drop_reg           <= '0;
        end else begin
            // configuration writes take effect at once; issue them only
            // while no request is in flight
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SERIAL_MODE: serial_mode_reg    <= cfg_wr_data[1:0];
                    REG_RECEIVE_EN:  receive_enable_reg <= cfg_wr_data[0];
                    REG_T1_RUNNING:  t1_running_reg     <= cfg_wr_data[0];
                    REG_T1_MODE:     t1_mode_reg        <= cfg_wr_data[1:0];
                    REG_BAUD_DOUBLE: baud_double_reg    <= cfg_wr_data[0];
                    REG_T1_FAST:     t1_fast_reg        <= cfg_wr_data[0];
                    REG_T1_RELOAD:   t1_reload_reg      <= cfg_wr_data[7:0];
                    REG_CLOCK_HZ:    clock_hz_reg       <= cfg_wr_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        // clear per-request result fields, then decode the kind
                        tx_valid_reg  <= 1'b0;
                        tx_byte_reg   <= '0;
                        overwrite_reg <= 1'b0;
                        mask_reg      <= '0;
                        baud_reg      <= '0;
                        frame_reg     <= '0;
                        delivered_reg <= 1'b0;
                        irq_reg       <= 1'b0;
                        now_reg       <= s_now_us;
                        state_reg     <= ST_OUT;
                        case (s_kind)
                            KIND_TX_WRITE: begin
                                tx_valid_reg  <= 1'b1;
                                tx_byte_reg   <= s_data_byte;
                                overwrite_reg <= ti_reg;
                                ti_reg        <= 1'b1;
                                irq_reg       <= 1'b1;
                                if (tx_mask != 2'b00) begin
                                    mask_reg <= tx_mask;
                                end else if (clock_hz_reg == '0) begin
                                    mask_reg <= MASK_BAUD;
                                end else begin
                                    // start the baud division
                                    rem_reg   <= '0;
                                    quo_reg   <= baud_num;
                                    den_reg   <= baud_den;
                                    cnt_reg   <= 6'(DIV_STEPS);
                                    phase_reg <= 1'b0;
                                    state_reg <= ST_DIV;
                                end
                            end
                            KIND_RX_PUSH: begin
                                if (fifo_full) begin
                                    drop_reg <= drop_inc;
                                end else begin
                                    wr_ptr_reg <= wr_inc;
                                end
                            end
                            KIND_DELIVER: begin
                                if (deliver_ok) begin
                                    if (ri_reg) begin
                                        // drop every queued byte, count with saturation
                                        rd_ptr_reg <= wr_ptr_reg;
                                        drop_reg   <= flush_sum[32] ? 32'hFFFF_FFFF
                                                                    : flush_sum[31:0];
                                    end else begin
                                        state_reg <= ST_READ;
                                    end
                                end
                            end
                            KIND_CLEAR: begin
                                if (s_clear_ti) begin
                                    ti_reg <= 1'b0;
                                end
                                if (s_clear_ri) begin
                                    ri_reg <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (cnt_reg != '0) begin
                        rem_reg <= take ? trial_sub[31:0] : trial[31:0];
                        quo_reg <= {quo_reg[31:0], take};
                        cnt_reg <= cnt_reg - 1'b1;
                    end else if (!phase_reg) begin
                        // baud done; a zero rate ends the request
                        baud_reg <= quo_reg[31:0];
                        if (quo_reg[31:0] == '0) begin
                            mask_reg  <= MASK_BAUD;
                            state_reg <= ST_OUT;
                        end else begin
                            rem_reg   <= '0;
                            quo_reg   <= serial_mode_reg[1] ? FRAME_NUM_11 : FRAME_NUM_10;
                            den_reg   <= quo_reg[31:0];
                            cnt_reg   <= 6'(DIV_STEPS);
                            phase_reg <= 1'b1;
                        end
                    end else begin
                        frame_reg <= quo_reg[23:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_READ: begin
                    // store read data is valid in the cycle after the request
                    data_buffer_reg <= rd_data_reg;
                    rd_ptr_reg      <= rd_inc;
                    ri_reg          <= 1'b1;
                    last_us_reg     <= now_reg;
                    ever_reg        <= 1'b1;
                    delivered_reg   <= 1'b1;
                    irq_reg         <= 1'b1;
                    state_reg       <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = (state_reg == ST_OUT);
    assign m_tx_valid       = tx_valid_reg;
    assign m_tx_byte        = tx_byte_reg;
    assign m_overwrite      = overwrite_reg;
    assign m_not_ready_mask = mask_reg;
    assign m_baud_hz        = baud_reg;
    assign m_frame_us       = frame_reg;
    assign m_buffer_value   = data_buffer_reg;
    assign m_delivered      = delivered_reg;
    assign m_dropped_total  = drop_reg;
    assign m_ti_flag        = ti_reg;
    assign m_ri_flag        = ri_reg;
    assign m_interrupt      = irq_reg;

`ifndef SYNTHESIS
    a_deliver_sets_ri: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_delivered) |-> m_ri_flag) else $error("delivery without RI");
    a_tx_sets_ti: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid) |-> (m_ti_flag && m_interrupt)) else $error("tx without TI");
    a_drop_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (drop_reg >= $past(drop_reg))) else $error("drop count fell");
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used <= DEPTH_P) else $error("FIFO overfilled");
    a_baud_zero_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid && m_baud_hz == '0) |-> m_not_ready_mask != 2'b00)
        else $error("zero baud without mask");
`endif

endmodule

>>> dv/mcs51_uart_model_test.sv
// Self-checking testbench for the 8051 serial port model: directed table plus
// random requests, checked against table expectations or an in-bench predictor of the port.
// Depends on rtl/mcs51_uart_pkg.sv and rtl/mcs51_uart_model.sv.
module mcs51_uart_model_test;
    import mcs51_uart_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FIFO_DEPTH  = RX_DEPTH_DEF;
    localparam int          MIN_GAP_US  = SPACING_US_DEF;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          DRAIN_WAIT  = 120;   // past the two divider passes
    localparam int          RAND_PHASES = 8;
    localparam int          PHASE_REQS  = 160;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [47:0] now_us;
        logic        clear_ti;
        logic        clear_ri;
    } uart_req_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        overwrite;
        logic [1:0]  not_ready_mask;
        logic [31:0] baud_hz;
        logic [23:0] frame_us;
        logic [7:0]  buffer_value;
        logic        delivered;
        logic [31:0] dropped_total;
        logic        ti_flag;
        logic        ri_flag;
        logic        interrupt;
    } uart_result_t;

    typedef struct packed {
        logic         is_cfg;
        logic [2:0]   cfg_idx;
        logic [30:0]  cfg_val;
        uart_req_t    req;
        logic         has_exp;
        uart_result_t exp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [7:0]  s_data_byte = '0;
    logic [47:0] s_now_us = '0;
    logic        s_clear_ti = 1'b0;
    logic        s_clear_ri = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    uart_result_t m_res;

    // typed expectation travels with the request, like the payload
    logic         s_has_exp = 1'b0;
    uart_result_t s_exp = '0;

    mcs51_uart_model u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_data_byte(s_data_byte), .s_now_us(s_now_us),
        .s_clear_ti(s_clear_ti), .s_clear_ri(s_clear_ri),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tx_valid(m_res.tx_valid), .m_tx_byte(m_res.tx_byte),
        .m_overwrite(m_res.overwrite), .m_not_ready_mask(m_res.not_ready_mask),
        .m_baud_hz(m_res.baud_hz), .m_frame_us(m_res.frame_us),
        .m_buffer_value(m_res.buffer_value), .m_delivered(m_res.delivered),
        .m_dropped_total(m_res.dropped_total), .m_ti_flag(m_res.ti_flag),
        .m_ri_flag(m_res.ri_flag), .m_interrupt(m_res.interrupt)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Predictor state: port registers plus receive FIFO and flags
    // ---------------------------------------------------------------
    logic [1:0]  sm_bits;
    logic        ren, tr1, smod, t1_fast;
    logic [1:0]  t1_mode;
    logic [7:0]  th1;
    logic [30:0] sys_clock;
    logic [7:0]  rx_fifo [FIFO_DEPTH];
    int unsigned wr_ptr, rd_ptr;
    logic [7:0]  sbuf;
    logic        ti, ri, got_first;
    logic [47:0] last_rx_us;
    logic [31:0] drops;

    uart_result_t expected_results[$];
    int  errors = 0;
    int  n_reqs = 0, n_tx_ready = 0, n_delivered = 0, n_results = 0;
    bit  calm = 1'b0;      // no idling on either side while set
    longint unsigned cycles = 0;

    function automatic void reset_port();
        sm_bits = '0; ren = 0; tr1 = 0; t1_mode = '0; smod = 0; t1_fast = 0;
        th1 = '0; sys_clock = CLOCK_HZ_RESET;
        wr_ptr = 0; rd_ptr = 0; sbuf = '0;
        ti = 0; ri = 0; got_first = 0; last_rx_us = '0; drops = '0;
    endfunction

    function automatic void write_port_reg(logic [2:0] idx, logic [30:0] val);
        case (idx)
            REG_SERIAL_MODE: sm_bits   = val[1:0];
            REG_RECEIVE_EN:  ren       = val[0];
            REG_T1_RUNNING:  tr1       = val[0];
            REG_T1_MODE:     t1_mode   = val[1:0];
            REG_BAUD_DOUBLE: smod      = val[0];
            REG_T1_FAST:     t1_fast   = val[0];
            REG_T1_RELOAD:   th1       = val[7:0];
            REG_CLOCK_HZ:    sys_clock = val;
            default: ;
        endcase
    endfunction

    function automatic int unsigned fifo_count();
        return (wr_ptr + 2 * FIFO_DEPTH - rd_ptr) % (2 * FIFO_DEPTH);
    endfunction

    function automatic void bump_drops();
        if (drops != 32'hFFFF_FFFF) drops++;
    endfunction

    // Advance the port by one request and return what it reports
    function automatic uart_result_t serial_port_step(uart_req_t rq);
        uart_result_t r;
        logic [63:0] divisor, rate;
        logic [47:0] since;
        r = '0;
        case (rq.kind)
            KIND_TX_WRITE: begin
                r.overwrite = ti;
                if (!sm_bits[0]) r.not_ready_mask |= MASK_MODE;
                if (!(tr1 && t1_mode == T1_MODE_RELOAD)) r.not_ready_mask |= MASK_BAUD;
                if (r.not_ready_mask == '0) begin
                    divisor = 64'd128 * (t1_fast ? 64'd1 : 64'd3) * (64'd256 - th1);
                    rate = (sys_clock == 0) ? 64'd0 :
                           (64'(sys_clock) * (smod ? 64'd2 : 64'd1)) / divisor;
                    r.baud_hz = rate[31:0];
                    if (r.baud_hz == 0) r.not_ready_mask |= MASK_BAUD;
                    else r.frame_us = 24'(((sm_bits[1] ? 64'd11 : 64'd10) * 64'd1000000)
                                          / 64'(r.baud_hz));
                end
                r.tx_valid = 1;
                r.tx_byte = rq.data_byte;
                ti = 1;
                r.interrupt = 1;
            end
            KIND_RX_PUSH: begin
                if (fifo_count() >= FIFO_DEPTH) bump_drops();
                else begin
                    rx_fifo[wr_ptr % FIFO_DEPTH] = rq.data_byte;
                    wr_ptr = (wr_ptr + 1) % (2 * FIFO_DEPTH);
                end
            end
            KIND_DELIVER: begin
                since = rq.now_us - last_rx_us;   // wraps modulo 2^48
                if (fifo_count() != 0 && ren && !(got_first && since < MIN_GAP_US)) begin
                    if (ri) begin
                        while (fifo_count() != 0) begin
                            rd_ptr = (rd_ptr + 1) % (2 * FIFO_DEPTH);
                            bump_drops();
                        end
                    end else begin
                        sbuf = rx_fifo[rd_ptr % FIFO_DEPTH];
                        rd_ptr = (rd_ptr + 1) % (2 * FIFO_DEPTH);
                        ri = 1;
                        last_rx_us = rq.now_us;
                        got_first = 1;
                        r.delivered = 1;
                        r.interrupt = 1;
                    end
                end
            end
            default: begin
                if (rq.clear_ti) ti = 0;
                if (rq.clear_ri) ri = 0;
            end
        endcase
        r.buffer_value = sbuf;
        r.dropped_total = drops;
        r.ti_flag = ti;
        r.ri_flag = ri;
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: track register writes, predict accepted requests,
    // check results in order
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        uart_req_t    rq;
        uart_result_t pred, e;
        if (aresetn) begin
            if (cfg_wr_en) write_port_reg(cfg_index, cfg_wr_data);
            if (s_valid && s_ready) begin
                rq = '{s_kind, s_data_byte, s_now_us, s_clear_ti, s_clear_ri};
                pred = serial_port_step(rq);
                if (pred.tx_valid && pred.baud_hz != 0) n_tx_ready++;
                if (pred.delivered) n_delivered++;
                n_reqs++;
                expected_results.push_back(s_has_exp ? s_exp : pred);
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with nothing expected, actual %p", $time, m_res);
                end else begin
                    e = expected_results.pop_front();
                    check_field("tx_valid", e.tx_valid, m_res.tx_valid);
                    check_field("tx_byte", e.tx_byte, m_res.tx_byte);
                    check_field("overwrite", e.overwrite, m_res.overwrite);
                    check_field("not_ready_mask", e.not_ready_mask, m_res.not_ready_mask);
                    check_field("baud_hz", e.baud_hz, m_res.baud_hz);
                    check_field("frame_us", e.frame_us, m_res.frame_us);
                    check_field("buffer_value", e.buffer_value, m_res.buffer_value);
                    check_field("delivered", e.delivered, m_res.delivered);
                    check_field("dropped_total", e.dropped_total, m_res.dropped_total);
                    check_field("ti_flag", e.ti_flag, m_res.ti_flag);
                    check_field("ri_flag", e.ri_flag, m_res.ri_flag);
                    check_field("interrupt", e.interrupt, m_res.interrupt);
                end
            end
        end
    end

    // Result side: stall in about 14 percent of cycles unless calm
    always @(posedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 14);

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("mcs51_uart_model test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver helpers
    // ---------------------------------------------------------------
    task automatic send_request(uart_req_t rq, logic has_exp, uart_result_t exp);
        if (!calm && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= rq.kind;
        s_data_byte <= rq.data_byte;
        s_now_us    <= rq.now_us;
        s_clear_ti  <= rq.clear_ti;
        s_clear_ri  <= rq.clear_ri;
        s_has_exp   <= has_exp;
        s_exp       <= exp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold until every result is back and the block has settled
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    stim_row_t table_rows[$];

    function automatic void add_req(logic [1:0] k, logic [7:0] b, logic [47:0] t,
                                    logic cti = 0, logic cri = 0);
        stim_row_t row = '0;
        row.req = '{k, b, t, cti, cri};
        table_rows.push_back(row);
    endfunction

    function automatic void add_req_exp(logic [1:0] k, logic [7:0] b, logic [47:0] t,
                                        logic cti, logic cri, uart_result_t exp);
        stim_row_t row = '0;
        row.req = '{k, b, t, cti, cri};
        row.has_exp = 1'b1;
        row.exp = exp;
        table_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [30:0] val);
        stim_row_t row = '0;
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        table_rows.push_back(row);
    endfunction

    function automatic void build_table();
        uart_result_t e;
        // reset settings: link not ready on both counts
        e = '0;
        add_req_exp(KIND_CLEAR, 8'h00, 48'd0, 1, 1, e);
        e = '0; e.tx_valid = 1; e.tx_byte = 8'hFF; e.not_ready_mask = MASK_MODE | MASK_BAUD;
        e.ti_flag = 1; e.interrupt = 1;
        add_req_exp(KIND_TX_WRITE, 8'hFF, 48'd0, 1, 1, e);
        e.tx_byte = 8'h00; e.overwrite = 1;              // TI still set
        add_req_exp(KIND_TX_WRITE, 8'h00, 48'd0, 0, 0, e);
        e = '0; e.ti_flag = 1;                           // tick on empty FIFO
        add_req_exp(KIND_DELIVER, 8'h00, 48'd0, 0, 0, e);
        add_req(KIND_RX_PUSH, 8'hA5, 48'd0);
        add_req(KIND_DELIVER, 8'h00, 48'd5000);          // REN clear: nothing
        // 9600 baud from 11.0592 MHz, 11-bit frame
        add_cfg(REG_SERIAL_MODE, 31'd3);
        add_cfg(REG_RECEIVE_EN, 31'd1);
        add_cfg(REG_T1_RUNNING, 31'd1);
        add_cfg(REG_T1_MODE, 31'(T1_MODE_RELOAD));
        add_cfg(REG_T1_RELOAD, 31'd253);
        add_req(KIND_TX_WRITE, 8'h3C, 48'd0);
        add_req(KIND_DELIVER, 8'h00, 48'hFFFF_FFFF_FFFF);
        add_req(KIND_RX_PUSH, 8'h5A, 48'd0);
        add_req(KIND_RX_PUSH, 8'h11, 48'd0);
        add_req(KIND_DELIVER, 8'h00, 48'd0);             // wraps: too early
        add_req(KIND_DELIVER, 8'h00, 48'd5000);          // RI set: drop the queue
        add_req(KIND_CLEAR, 8'h00, 48'd0, 1, 0);
        add_req(KIND_CLEAR, 8'h00, 48'd0, 0, 1);
        add_req(KIND_RX_PUSH, 8'h77, 48'd0);
        add_req(KIND_DELIVER, 8'h00, 48'd5999);          // past the spacing: delivers
        add_req(KIND_DELIVER, 8'h00, 48'd6000);
        // fastest divisor, largest clock
        add_cfg(REG_T1_RELOAD, 31'd255);
        add_cfg(REG_T1_FAST, 31'd1);
        add_cfg(REG_BAUD_DOUBLE, 31'd1);
        add_cfg(REG_CLOCK_HZ, 31'h7FFF_FFFF);
        add_req(KIND_TX_WRITE, 8'h81, 48'd0);
        add_cfg(REG_CLOCK_HZ, 31'd0);                    // unknown clock
        add_req(KIND_TX_WRITE, 8'h42, 48'd0);
        add_cfg(REG_CLOCK_HZ, 31'd1);                    // quotient rounds to zero
        add_cfg(REG_T1_RELOAD, 31'd0);
        add_req(KIND_TX_WRITE, 8'h24, 48'd0);
        add_cfg(REG_CLOCK_HZ, 31'(CLOCK_HZ_RESET));
        add_cfg(REG_SERIAL_MODE, 31'd1);                 // 10-bit frame
        add_req(KIND_TX_WRITE, 8'h99, 48'd0);
        add_cfg(REG_SERIAL_MODE, 31'd2);                 // wrong mode only
        add_req(KIND_TX_WRITE, 8'h66, 48'd0);
        add_cfg(REG_T1_MODE, 31'd1);                     // both reasons
        add_req(KIND_TX_WRITE, 8'hC3, 48'd0);
    endfunction

    // ---------------------------------------------------------------
    // Random stimulus
    // ---------------------------------------------------------------
    logic [47:0] vtime = '0;

    task automatic random_settings();
        logic [30:0] clk;
        bit ready_link;
        ready_link = ($urandom_range(99) < 75);
        case ($urandom_range(9))
            0:       clk = 31'd0;
            1:       clk = 31'h7FFF_FFFF;
            2:       clk = 31'($urandom_range(20000));
            3, 4:    clk = 31'($urandom);
            default: clk = 31'(CLOCK_HZ_RESET);
        endcase
        write_reg(REG_SERIAL_MODE, ready_link ? 31'($urandom_range(1) * 2 + 1)
                                              : 31'($urandom_range(3)));
        write_reg(REG_RECEIVE_EN, ($urandom_range(99) < 80) ? 31'd1 : 31'd0);
        write_reg(REG_T1_RUNNING, ready_link ? 31'd1 : 31'($urandom_range(1)));
        write_reg(REG_T1_MODE, ready_link ? 31'(T1_MODE_RELOAD) : 31'($urandom_range(3)));
        write_reg(REG_BAUD_DOUBLE, 31'($urandom_range(1)));
        write_reg(REG_T1_FAST, 31'($urandom_range(1)));
        write_reg(REG_T1_RELOAD, 31'($urandom_range(255)));
        write_reg(REG_CLOCK_HZ, clk);
    endtask

    function automatic uart_req_t random_request();
        uart_req_t rq;
        int unsigned pick;
        pick = $urandom_range(99);
        rq.kind = (pick < 20) ? KIND_TX_WRITE : (pick < 50) ? KIND_RX_PUSH :
                  (pick < 80) ? KIND_DELIVER : KIND_CLEAR;
        rq.data_byte = 8'($urandom);
        rq.clear_ti = 1'($urandom);
        rq.clear_ri = 1'($urandom);
        // advance virtual time: mostly past the spacing, sometimes short or a jump
        pick = $urandom_range(99);
        if (pick < 60)      vtime = vtime + 48'($urandom_range(MIN_GAP_US, 3 * MIN_GAP_US));
        else if (pick < 85) vtime = vtime + 48'($urandom_range(MIN_GAP_US - 1));
        else if (pick < 95) vtime = vtime + 48'($urandom);
        else                vtime = {16'($urandom), 32'($urandom)};
        rq.now_us = vtime;
        return rq;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        reset_port();
        build_table();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; each register change waits for the block to go idle
        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg) begin
                wait_idle();
                write_reg(table_rows[i].cfg_idx, table_rows[i].cfg_val);
            end else begin
                send_request(table_rows[i].req, table_rows[i].has_exp, table_rows[i].exp);
            end
        end

        // random phases, each under fresh settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            random_settings();
            calm = (ph == 2);            // one long stretch without idling
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (ph == 4 && n == PHASE_REQS / 2) begin
                    // hold the sender until the block has answered everything
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (expected_results.size() != 0) @(posedge aclk);
                end
                send_request(random_request(), 1'b0, '0);
            end
            calm = 1'b0;
        end

        wait_idle();
        $display("Ran %0d requests (%0d results): %0d transmits with a live baud rate,",
                 n_reqs, n_results, n_tx_ready);
        $display("%0d receive deliveries, %0d bytes dropped, %0d mismatching fields.",
                 n_delivered, drops, errors);
        if (errors == 0)
            $display("mcs51_uart_model test passed");
        else
            $display("mcs51_uart_model test failed");
        $finish;
    end

endmodule
